[design/plti_pkg.sv]
// Shared constants, types and codes for the piecewise-linear gain table.
package plti_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = ADDR_W + 1;
  localparam int FREQ_W = 24;
  localparam int GAIN_W = 32;
  localparam int PROD_W = GAIN_W + FREQ_W;
  localparam int STEP_W = $clog2(PROD_W);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_BELOW  = 2'd1,
    ST_ABOVE  = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [FREQ_W-1:0] freq;
  } entry_t;

endpackage

[design/plti_table.sv]
// Point table memory with one write port and one registered read port.
module plti_table (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [plti_pkg::ADDR_W-1:0] waddr_i,
  input  plti_pkg::entry_t            wdata_i,
  input  logic                        re_i,
  input  logic [plti_pkg::ADDR_W-1:0] raddr_i,
  output plti_pkg::entry_t            rdata_o
);

  plti_pkg::entry_t mem_q [plti_pkg::MAX_POINTS];
  plti_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/plti_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module plti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [plti_pkg::PROD_W-1:0] dividend_i,
  input  logic [plti_pkg::FREQ_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [plti_pkg::GAIN_W-1:0] quotient_o
);

  logic                        run_q;
  logic                        done_q;
  logic [plti_pkg::STEP_W-1:0] cnt_q;
  logic [plti_pkg::PROD_W-1:0] acc_q;
  logic [plti_pkg::FREQ_W-1:0] rem_q;
  logic [plti_pkg::FREQ_W-1:0] div_q;
  logic [plti_pkg::FREQ_W:0]   trial;
  logic [plti_pkg::FREQ_W:0]   diff;
  logic                        fits;

  assign trial = {rem_q, acc_q[plti_pkg::PROD_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= plti_pkg::STEP_W'(plti_pkg::PROD_W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      acc_q <= {acc_q[plti_pkg::PROD_W-2:0], fits};
      rem_q <= fits ? diff[plti_pkg::FREQ_W-1:0] : trial[plti_pkg::FREQ_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q[plti_pkg::GAIN_W-1:0];

endmodule

[design/piecewise_linear_table_interp_top.sv]
// Top level of the piecewise-linear gain table with search and interpolation sequencer.
//
// Input transactions arrive on the s_axis group; tuser selects a load or a query.
// A load writes one (frequency, gain) point into the table and gives no output
// transaction. A query walks the table from entry zero, one entry per cycle
// through the table's registered read port, until it meets the first frequency
// above the query. Clamped or empty cases finish right there. An interpolation
// then passes through the multiplier and the bit-serial divider, which runs 56
// quotient steps. s_axis_tready is high only while the sequencer is idle, so
// one transaction is in work at a time.
// Each query yields one m_axis transaction: tdata holds the gain, tuser the status.
// The result waits in an output register; while the receiver stalls, the block
// still accepts the next transaction and holds a finished query until the
// register frees up. Reset clears the point count to zero and the control
// state; table contents are undefined until loaded.
module piecewise_linear_table_interp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,     // num_points
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,    // entry_index[7:0], frequency[31:8], entry_gain[63:32]
  input  logic [0:0]  s_axis_tuser,    // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // gain[31:0]
  output logic [1:0]  m_axis_tuser     // status[1:0]
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  localparam int AW = plti_pkg::ADDR_W;
  localparam int CW = plti_pkg::CNT_W;
  localparam int FW = plti_pkg::FREQ_W;
  localparam int GW = plti_pkg::GAIN_W;
  localparam int PW = plti_pkg::PROD_W;

  state_e state_q, state_d;

  logic [CW-1:0] num_points_q;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pidx_q;
  logic          pend_q;
  logic [FW-1:0] qf_q;
  logic [FW-1:0] f0_q;
  logic [GW-1:0] g0_q;
  logic [GW-1:0] mag_q;
  logic [FW-1:0] dq_q;
  logic [FW-1:0] df_q;
  logic          neg_q;
  logic [PW-1:0] prod_q;
  logic          start_q;
  logic [GW-1:0] res_gain_q, res_gain_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          out_valid_q;
  logic [GW-1:0] out_gain_q;
  logic [1:0]    out_status_q;

  logic             in_acc;
  logic             in_mode;
  logic [AW-1:0]    in_index;
  plti_pkg::entry_t in_entry;
  logic             rd_en;
  plti_pkg::entry_t rd_entry;
  logic             found;
  logic [GW:0]      dg;
  logic             div_done;
  logic [GW-1:0]    quot;
  logic             out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tuser[0];
  assign in_index      = s_axis_tdata[AW-1:0];
  assign in_entry.freq = s_axis_tdata[FW+7:8];
  assign in_entry.gain = s_axis_tdata[63:32];

  assign rd_en = (state_q == S_SEARCH) && (ptr_q < n_q);

  plti_table u_table (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_mode == plti_pkg::MODE_LOAD)),
    .waddr_i (in_index),
    .wdata_i (in_entry),
    .re_i    (rd_en),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  plti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (prod_q),
    .divisor_i  (df_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign found = rd_entry.freq > qf_q;
  assign dg    = {rd_entry.gain[GW-1], rd_entry.gain} - {g0_q[GW-1], g0_q};

  always_comb begin
    n_d = (num_points_q > CW'(plti_pkg::MAX_POINTS)) ? CW'(plti_pkg::MAX_POINTS)
                                                     : num_points_q;
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    res_gain_d   = res_gain_q;
    res_status_d = res_status_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_mode == plti_pkg::MODE_QUERY)) begin
          ptr_d = '0;
          if (n_d == '0) begin
            res_gain_d   = '0;
            res_status_d = plti_pkg::ST_EMPTY;
            state_d      = S_RESULT;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (rd_en) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (pend_q) begin
          if (found) begin
            if (pidx_q == '0) begin
              res_gain_d   = rd_entry.gain;
              res_status_d = plti_pkg::ST_BELOW;
              state_d      = S_RESULT;
            end else begin
              state_d = S_MUL;
            end
          end else if (pidx_q == n_q - 1'b1) begin
            res_gain_d   = rd_entry.gain;
            res_status_d = (rd_entry.freq == qf_q) ? plti_pkg::ST_INTERP
                                                   : plti_pkg::ST_ABOVE;
            state_d      = S_RESULT;
          end
        end
      end
      S_MUL: begin
        state_d = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done) begin
          res_gain_d   = neg_q ? (g0_q - quot) : (g0_q + quot);
          res_status_d = plti_pkg::ST_INTERP;
          state_d      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      num_points_q <= '0;
      ptr_q        <= '0;
      pend_q       <= 1'b0;
      start_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= rd_en;
      start_q <= (state_q == S_MUL);
      if (cfg_we_i) begin
        num_points_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_gain_q   <= res_gain_d;
    res_status_q <= res_status_d;
    if (in_acc) begin
      qf_q <= in_entry.freq;
      n_q  <= n_d;
    end
    if (rd_en) begin
      pidx_q <= ptr_q;
    end
    if ((state_q == S_SEARCH) && pend_q) begin
      if (found) begin
        dq_q  <= qf_q - f0_q;
        df_q  <= rd_entry.freq - f0_q;
        neg_q <= dg[GW];
        mag_q <= dg[GW] ? GW'(-dg) : dg[GW-1:0];
      end else begin
        f0_q <= rd_entry.freq;
        g0_q <= rd_entry.gain;
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= PW'(mag_q) * PW'(dq_q);
    end
    if (out_load) begin
      out_gain_q   <= res_gain_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_gain_q;
  assign m_axis_tuser  = out_status_q;

endmodule
